// File: hdl/scl_pkg.sv
// shared constants for the sorted char list: sizes, opcodes and status codes
package scl_pkg;

  localparam int SCL_CAPACITY = 16;
  localparam int SCL_MAX_OUT  = 16;
  localparam int SCL_DW       = 8;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_DUMP   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef logic [SCL_DW-1:0] byte_t;

endpackage

// File: hdl/sorted_char_list.sv
// sorted char list top level: operation sequencer, entry store and result register
// append, full insert, rejected remove and empty dump go from idle straight to S_DONE
// sorted insert: ripple pass then tail write; remove at p pulls later entries down
// dump streams one entry per cycle while not stalled, min(count,16) results in all
// one operation at a time; the store port (one read, one write a cycle) sets the pace
// reset clears the count and all control; the store is not cleared and needs no sweep
module sorted_char_list
  import scl_pkg::*;
#(
  parameter int CAPACITY = SCL_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  logic signed [7:0] in_value,
  input  logic [3:0]        in_position,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] out_item,
  output logic              out_last,
  output logic [1:0]        out_status,
  output logic [4:0]        out_entry_count,
  output logic              out_empty_res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;  // ripple pass: find slot, push later entries up
  localparam logic [2:0] S_TAIL = 3'd2;  // write the carried entry at the old end
  localparam logic [2:0] S_REM  = 3'd3;  // pull later entries down over the gap
  localparam logic [2:0] S_DMP  = 3'd4;  // stream entries out
  localparam logic [2:0] S_DONE = 3'd5;  // post the single result of the request

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] k_r, k_nxt;
  byte_t         carry_r, carry_nxt;
  logic          placed_r, placed_nxt;
  logic [1:0]    stat_r, stat_nxt;

  // dump read tracking: rdata holds an entry not yet moved to the result register
  logic          rd_vld_r, rd_vld_nxt;
  logic          rd_last_r, rd_last_nxt;
  logic          rd_done_r, rd_done_nxt;

  // result register
  logic          out_vld_r;
  byte_t         out_item_r;
  logic          out_last_r;
  logic [1:0]    out_status_r;
  logic [4:0]    out_count_r;
  logic          out_empty_r;

  // store port
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  byte_t         wdata, rdata;

  // result load
  logic          ld;
  byte_t         ld_item;
  logic          ld_last;
  logic [1:0]    ld_stat;

  logic          acc;
  logic          out_free;
  logic          mv;
  logic          issue;
  logic          match;
  logic          wr_ins;
  int            dump_n;
  logic [CW+4:0] fill_x;

  scl_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign acc      = in_valid && !in_stall;
  assign out_free = !out_vld_r || !out_stall;
  assign fill_x   = (CW + 5)'(fill_r);

  // a dump shows at most the first sixteen entries
  assign dump_n = (32'(fill_r) > SCL_MAX_OUT) ? SCL_MAX_OUT : 32'(fill_r);

  // insert: the first entry not below the new value takes the new value
  assign match  = !placed_r && ($signed(rdata) >= $signed(carry_r));
  assign wr_ins = placed_r || match;

  assign mv    = (state_r == S_DMP) && rd_vld_r && out_free;
  assign issue = (state_r == S_DMP) && !rd_done_r && (!rd_vld_r || mv);

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    k_nxt       = k_r;
    carry_nxt   = carry_r;
    placed_nxt  = placed_r;
    stat_nxt    = stat_r;
    rd_vld_nxt  = rd_vld_r;
    rd_last_nxt = rd_last_r;
    rd_done_nxt = rd_done_r;
    we          = 1'b0;
    waddr       = k_r;
    wdata       = carry_r;
    re          = 1'b0;
    raddr       = k_r;
    ld          = 1'b0;
    ld_item     = '0;
    ld_last     = 1'b1;
    ld_stat     = stat_r;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (in_opcode)
            OP_INSERT, OP_APPEND: begin
              if (32'(fill_r) >= CAPACITY) begin
                stat_nxt  = ST_FULL;
                state_nxt = S_DONE;
              end else if (in_opcode == OP_APPEND || fill_r == '0) begin
                // goes straight to the end
                we        = 1'b1;
                waddr     = fill_r[AW-1:0];
                wdata     = in_value;
                fill_nxt  = fill_r + CW'(1);
                stat_nxt  = ST_OK;
                state_nxt = S_DONE;
              end else begin
                re         = 1'b1;
                raddr      = '0;
                k_nxt      = '0;
                carry_nxt  = in_value;
                placed_nxt = 1'b0;
                stat_nxt   = ST_OK;
                state_nxt  = S_INS;
              end
            end
            OP_REMOVE: begin
              if (32'(in_position) >= 32'(fill_r)) begin
                stat_nxt  = ST_RANGE;
                state_nxt = S_DONE;
              end else if (32'(in_position) + 1 == 32'(fill_r)) begin
                // last entry: nothing to pull down
                fill_nxt  = fill_r - CW'(1);
                stat_nxt  = ST_OK;
                state_nxt = S_DONE;
              end else begin
                re        = 1'b1;
                raddr     = AW'(in_position) + AW'(1);
                k_nxt     = AW'(in_position);
                stat_nxt  = ST_OK;
                state_nxt = S_REM;
              end
            end
            OP_DUMP: begin
              if (fill_r == '0) begin
                stat_nxt  = ST_EMPTY;
                state_nxt = S_DONE;
              end else begin
                k_nxt       = '0;
                rd_vld_nxt  = 1'b0;
                rd_last_nxt = 1'b0;
                rd_done_nxt = 1'b0;
                stat_nxt    = ST_OK;
                state_nxt   = S_DMP;
              end
            end
          endcase
        end
      end

      S_INS: begin
        // rdata is entry k; once placed, every entry moves up by one
        we    = wr_ins;
        waddr = k_r;
        wdata = carry_r;
        if (wr_ins) begin
          carry_nxt  = rdata;
          placed_nxt = 1'b1;
        end
        if (32'(k_r) + 1 < 32'(fill_r)) begin
          re    = 1'b1;
          raddr = k_r + AW'(1);
          k_nxt = k_r + AW'(1);
        end else begin
          state_nxt = S_TAIL;
        end
      end

      S_TAIL: begin
        // carry is the displaced last entry, or the new value if it sorts last
        we        = 1'b1;
        waddr     = fill_r[AW-1:0];
        wdata     = carry_r;
        fill_nxt  = fill_r + CW'(1);
        state_nxt = S_DONE;
      end

      S_REM: begin
        // rdata is entry k+1, moved down to k
        we    = 1'b1;
        waddr = k_r;
        wdata = rdata;
        if (32'(k_r) + 2 < 32'(fill_r)) begin
          re    = 1'b1;
          raddr = k_r + AW'(1) + AW'(1);
          k_nxt = k_r + AW'(1);
        end else begin
          fill_nxt  = fill_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_DMP: begin
        if (mv) begin
          ld         = 1'b1;
          ld_item    = rdata;
          ld_last    = rd_last_r;
          ld_stat    = ST_OK;
          rd_vld_nxt = 1'b0;
          if (rd_last_r) begin
            state_nxt = S_IDLE;
          end
        end
        // next read lands in rdata as the current one moves out
        if (issue) begin
          re          = 1'b1;
          raddr       = k_r;
          rd_vld_nxt  = 1'b1;
          rd_last_nxt = (32'(k_r) + 1 == dump_n);
          rd_done_nxt = (32'(k_r) + 1 == dump_n);
          k_nxt       = k_r + AW'(1);
        end
      end

      S_DONE: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_item   = '0;
          ld_last   = 1'b1;
          ld_stat   = stat_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
      rd_done_r <= 1'b0;
      placed_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      rd_vld_r  <= rd_vld_nxt;
      rd_last_r <= rd_last_nxt;
      rd_done_r <= rd_done_nxt;
      placed_r  <= placed_nxt;
      if (ld) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    carry_r <= carry_nxt;
    stat_r  <= stat_nxt;
    if (ld) begin
      out_item_r   <= ld_item;
      out_last_r   <= ld_last;
      out_status_r <= ld_stat;
      out_count_r  <= fill_x[4:0];
      out_empty_r  <= (fill_r == '0);
    end
  end

  assign out_valid       = out_vld_r;
  assign out_item        = out_item_r;
  assign out_last        = out_last_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_empty_res   = out_empty_r;

endmodule

// File: hdl/scl_mem.sv
// entry store: one write port, one read port with registered read data
module scl_mem
  import scl_pkg::*;
#(
  parameter int DEPTH = SCL_CAPACITY
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  byte_t                    wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output byte_t                    rdata
);

  byte_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: tb/sv/sorted_char_list_checker.sv
// sorted char list checker: predicts the results of each request and compares them
`timescale 1ns / 100ps

module sorted_char_list_checker
  import scl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  logic signed [7:0] in_value,
  input  logic [3:0]        in_position,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic signed [7:0] out_item,
  input  logic              out_last,
  input  logic [1:0]        out_status,
  input  logic [4:0]        out_entry_count,
  input  logic              out_empty_res,
  output int                fails,
  output int                pending,
  output int                taken,
  output int                results,
  output int                full_seen,
  output int                range_seen,
  output int                void_seen
);

  typedef struct packed {
    byte_t      item;
    logic       last;
    logic [1:0] status;
    logic [4:0] count;
    logic       empty;
  } list_result_t;

  byte_t        slots [SCL_CAPACITY];
  int           held;
  list_result_t due_q [$];
  list_result_t head;
  int           nerr, ntaken, nres, nfull, nrange, nvoid;

  // result fields reflect the list after the operation
  function automatic list_result_t make_result(byte_t item, logic last, logic [1:0] st);
    list_result_t r;
    r.item   = item;
    r.last   = last;
    r.status = st;
    r.count  = 5'(held);
    r.empty  = (held == 0);
    return r;
  endfunction

  function automatic void match_field(string name, int want, int got);
    if (want != got) begin
      nerr++;
      if (nerr <= 40)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  task automatic apply_request(logic [1:0] op, byte_t val, logic [3:0] pos);
    int at;
    int n;
    int i;
    case (op)
      OP_INSERT, OP_APPEND: begin
        if (held >= SCL_CAPACITY) begin
          due_q.push_back(make_result('0, 1'b1, ST_FULL));
        end else begin
          at = held;
          if (op == OP_INSERT) begin
            at = 0;
            while (at < held && $signed(slots[at]) < $signed(val)) at++;
          end
          for (i = held; i > at; i--) slots[i] = slots[i-1];
          slots[at] = val;
          held++;
          due_q.push_back(make_result('0, 1'b1, ST_OK));
        end
      end
      OP_REMOVE: begin
        if (pos >= held) begin
          due_q.push_back(make_result('0, 1'b1, ST_RANGE));
        end else begin
          for (i = pos; i + 1 < held; i++) slots[i] = slots[i+1];
          held--;
          due_q.push_back(make_result('0, 1'b1, ST_OK));
        end
      end
      OP_DUMP: begin
        if (held == 0) begin
          due_q.push_back(make_result('0, 1'b1, ST_EMPTY));
        end else begin
          n = (held < SCL_MAX_OUT) ? held : SCL_MAX_OUT;
          for (i = 0; i < n; i++)
            due_q.push_back(make_result(slots[i], i == n - 1, ST_OK));
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held = 0;
      due_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        nres++;
        if (due_q.size() == 0) begin
          nerr++;
          if (nerr <= 40)
            $display("%0t: unexpected result, expected none, actual item %0d status %0d",
                     $time, out_item, out_status);
        end else begin
          head = due_q.pop_front();
          match_field("item", $signed(head.item), out_item);
          match_field("last", head.last, out_last);
          match_field("status", head.status, out_status);
          match_field("entry_count", head.count, out_entry_count);
          match_field("empty_res", head.empty, out_empty_res);
          if (head.status == ST_FULL) nfull++;
          if (head.status == ST_RANGE) nrange++;
          if (head.status == ST_EMPTY) nvoid++;
        end
      end
      if (in_valid && !in_stall) begin
        ntaken++;
        apply_request(in_opcode, in_value, in_position);
      end
    end
    fails      <= nerr + due_q.size();
    pending    <= due_q.size();
    taken      <= ntaken;
    results    <= nres;
    full_seen  <= nfull;
    range_seen <= nrange;
    void_seen  <= nvoid;
  end

endmodule

// File: tb/sv/sorted_char_list_tb.sv
// sorted char list testbench top: clock, reset, request and stall stimulus, verdict
`timescale 1ns / 100ps

module sorted_char_list_tb;
  import scl_pkg::*;

  localparam int RANDOM_ITEMS = 392;
  localparam int QUIET_TAIL   = 60;      // last requests go out with no idling
  localparam int CYCLE_LIMIT  = 400000;  // far above the slowest legal run

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_opcode;
  logic signed [7:0] in_value;
  logic [3:0]        in_position;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [7:0] out_item;
  logic              out_last;
  logic [1:0]        out_status;
  logic [4:0]        out_entry_count;
  logic              out_empty_res;

  int   fails, pending, taken, results, full_seen, range_seen, void_seen;
  int   n_sent;
  int   op_seen [4];
  int   cycles;
  logic idling;
  int   stall_left = 0;

  always #5 clk = ~clk;

  sorted_char_list dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item),
    .out_last        (out_last),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_empty_res   (out_empty_res)
  );

  sorted_char_list_checker list_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item),
    .out_last        (out_last),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_empty_res   (out_empty_res),
    .fails           (fails),
    .pending         (pending),
    .taken           (taken),
    .results         (results),
    .full_seen       (full_seen),
    .range_seen      (range_seen),
    .void_seen       (void_seen)
  );

  // result side backpressure: random stall bursts start only while idling is on
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // present one request and hold it until the block takes it
  task automatic issue(logic [1:0] op, byte_t val, logic [3:0] pos);
    if (idling && $urandom_range(0, 4) == 0) begin
      // idle gap, payload wanders while valid is low
      in_valid    <= 1'b0;
      in_opcode   <= 2'($urandom);
      in_value    <= 8'($urandom);
      in_position <= 4'($urandom);
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_value    <= val;
    in_position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    op_seen[op]++;
  endtask

  // watchdog: a hung handshake or a missing result ends here
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still due", cycles, pending);
    $display("sorted_char_list_tb: errors");
    $finish;
  end

  initial begin
    int       i;
    int       n;
    int       burst;
    int       kind;
    int       roll;
    logic     quiet;
    byte_t    v;
    logic [3:0] p;
    logic [1:0] op;

    // every block input known from time zero
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_opcode   = OP_INSERT;
    in_value    = '0;
    in_position = '0;
    idling      = 1'b1;
    n_sent      = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty list corner cases
    issue(OP_DUMP, 8'h00, 4'd0);      // dump of an empty list
    issue(OP_REMOVE, 8'h00, 4'd0);    // remove with nothing held

    // sorted insert at both ends, in the middle and ahead of an equal value
    issue(OP_INSERT, 8'h00, 4'd0);
    issue(OP_INSERT, 8'h7f, 4'd0);
    issue(OP_INSERT, 8'h80, 4'd0);
    issue(OP_INSERT, 8'h00, 4'd15);
    issue(OP_APPEND, 8'hff, 4'd0);    // append ignores order
    issue(OP_DUMP, 8'h55, 4'd9);

    // remove the head, a position beyond the count, and the tail
    issue(OP_REMOVE, 8'h00, 4'd0);
    issue(OP_REMOVE, 8'h00, 4'd15);
    issue(OP_REMOVE, 8'h00, 4'd3);

    // top the list up to capacity, then push into a full list
    for (i = 0; i < 13; i++)
      issue(OP_APPEND, byte_t'(i * 37 + 5), 4'(i));
    issue(OP_INSERT, 8'h80, 4'd0);
    issue(OP_APPEND, 8'h7f, 4'd0);
    issue(OP_DUMP, 8'haa, 4'd5);      // longest dump, sixteen results
    issue(OP_REMOVE, 8'h00, 4'd15);   // last slot of a full list

    // random part: phases that grow, churn or drain the list
    n = 0;
    while (n < RANDOM_ITEMS) begin
      kind  = $urandom_range(0, 2);
      burst = $urandom_range(20, 50);
      if (burst > RANDOM_ITEMS - n)
        burst = RANDOM_ITEMS - n;
      quiet = ($urandom_range(0, 3) == 0);
      repeat (burst) begin
        roll = $urandom_range(0, 99);
        case (kind)
          0: op = (roll < 45) ? OP_INSERT : (roll < 65) ? OP_APPEND :
                  (roll < 80) ? OP_REMOVE : OP_DUMP;
          1: op = (roll < 30) ? OP_INSERT : (roll < 45) ? OP_APPEND :
                  (roll < 75) ? OP_REMOVE : OP_DUMP;
          default: op = (roll < 15) ? OP_INSERT : (roll < 25) ? OP_APPEND :
                        (roll < 80) ? OP_REMOVE : OP_DUMP;
        endcase
        // extremes and repeats now and then so equal compares happen
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 4))
            0: v = 8'h80;
            1: v = 8'hff;
            2: v = 8'h00;
            3: v = 8'h01;
            default: v = 8'h7f;
          endcase
        end else begin
          v = 8'($urandom);
        end
        // low positions mostly hit live entries while draining
        if (kind == 2 && $urandom_range(0, 1) == 0)
          p = 4'($urandom_range(0, 3));
        else
          p = 4'($urandom_range(0, 15));
        idling <= !quiet && (n < RANDOM_ITEMS - QUIET_TAIL);
        issue(op, v, p);
        n++;
      end
    end
    in_valid <= 1'b0;

    // drain: every request taken and every result back, then a short tail
    while (taken != n_sent || pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("requests sent: %0d (insert %0d, append %0d, remove %0d, dump %0d)",
             n_sent, op_seen[OP_INSERT], op_seen[OP_APPEND], op_seen[OP_REMOVE],
             op_seen[OP_DUMP]);
    $display("results compared: %0d, of which full %0d, bad position %0d, empty dump %0d",
             results, full_seen, range_seen, void_seen);
    if (fails == 0)
      $display("sorted_char_list_tb: clean");
    else
      $display("sorted_char_list_tb: errors");
    $finish;
  end

endmodule
